[sv/aeios_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeios_pkg
// Shared types and constants of the aligned even I/O splitter.
// ----------------------------------------------------------------------------
package aeios_pkg;

    localparam int DEF_MAX_CHUNKS = 64;
    localparam int OFF_W   = 62;
    localparam int COFF_W  = 63;
    localparam int AMT_W   = 31;
    localparam int BLK_W   = 21;
    localparam int DVD_W   = 64;
    localparam int REL_W   = 36;
    localparam int CFG_IDX_W = 2;

    localparam logic [BLK_W-1:0] BLK_RESET = BLK_W'(4096);
    localparam logic [AMT_W-1:0] MOP_RESET = AMT_W'(131072);

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OP_SIZE = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD0,
        ST_LEFT,
        ST_IDEAL,
        ST_EMOD,
        ST_LMOD,
        ST_NMOD,
        ST_STEP,
        ST_ERR
    } state_t;

    typedef enum logic [2:0] {
        DIV_MOD0,
        DIV_LEFT,
        DIV_IDEAL,
        DIV_EMOD,
        DIV_LMOD,
        DIV_NMOD
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     restart;
        logic     div_go;
        div_sel_t div_sel;
        logic     cap;
        logic     advance;
        logic     emit_final;
        logic     emit_chunk;
        logic     emit_err;
    } cmd_t;

    typedef struct packed {
        logic amount_zero;
        logic div_done;
        logic left_one;
        logic count_full;
        logic no_adv;
    } status_t;

endpackage
`default_nettype wire

[sv/aeios_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeios_div
// Restoring radix-2 divider, one quotient bit per cycle, 32 or 64 steps.
// ----------------------------------------------------------------------------
module aeios_div
    import aeios_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic             wide,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [AMT_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quot,
    output logic [AMT_W-1:0]      rmd
);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [AMT_W-1:0] rem_reg, rem_next;
    logic [AMT_W-1:0] dsr_reg, dsr_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [AMT_W:0]   trial;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            dvd_next = wide ? dividend : {dividend[31:0], 32'b0};
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = wide ? 7'd64 : 7'd32;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = AMT_W'(trial - {1'b0, dsr_reg});
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[AMT_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rmd  = rem_reg;

endmodule
`default_nettype wire

[sv/aeios_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeios_ctrl
// Sequencer: a planning pass that only checks, then a pass that emits.
// ----------------------------------------------------------------------------
module aeios_ctrl
    import aeios_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output logic         busy,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   issued_reg, issued_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pass_reg   <= 1'b0;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            issued_reg <= issued_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        issued_next = issued_reg;
        cmd         = '0;
        cmd.div_sel = DIV_MOD0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    pass_next = 1'b0;
                    if (!status.amount_zero)
                        state_next = ST_MOD0;
                end
            end
            ST_ERR:
            begin
                cmd.emit_err = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_STEP:
            begin
                if (status.no_adv)
                    state_next = ST_ERR;
                else
                begin
                    cmd.advance    = 1'b1;
                    cmd.emit_chunk = pass_reg;
                    state_next     = ST_LEFT;
                end
            end
            default:
            begin
                unique case (state_reg)
                    ST_LEFT:  cmd.div_sel = DIV_LEFT;
                    ST_IDEAL: cmd.div_sel = DIV_IDEAL;
                    ST_EMOD:  cmd.div_sel = DIV_EMOD;
                    ST_LMOD:  cmd.div_sel = DIV_LMOD;
                    ST_NMOD:  cmd.div_sel = DIV_NMOD;
                    default:  cmd.div_sel = DIV_MOD0;
                endcase
                if (!issued_reg)
                begin
                    if (state_reg == ST_LEFT && status.count_full)
                        state_next = ST_ERR;
                    else
                    begin
                        cmd.div_go  = 1'b1;
                        issued_next = 1'b1;
                    end
                end
                else if (status.div_done)
                begin
                    cmd.cap     = 1'b1;
                    issued_next = 1'b0;
                    unique case (state_reg)
                        ST_MOD0:  state_next = ST_LEFT;
                        ST_LEFT:
                        begin
                            if (!status.left_one)
                                state_next = ST_IDEAL;
                            else if (pass_reg)
                            begin
                                cmd.emit_final = 1'b1;
                                state_next     = ST_IDLE;
                            end
                            else
                            begin
                                cmd.restart = 1'b1;
                                pass_next   = 1'b1;
                            end
                        end
                        ST_IDEAL: state_next = ST_EMOD;
                        ST_EMOD:  state_next = ST_LMOD;
                        ST_LMOD:  state_next = ST_NMOD;
                        default:  state_next = ST_STEP;
                    endcase
                end
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

[sv/aeios_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeios_dp
// Datapath: config registers, request state, divider operands, result regs.
// ----------------------------------------------------------------------------
module aeios_dp
    import aeios_pkg::*;
#(
    parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic [OFF_W-1:0]     start_offset,
    input  wire logic [AMT_W-1:0]     byte_amount,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMT_W-1:0]     cfg_data,
    output logic                      result_valid,
    output logic [COFF_W-1:0]         chunk_offset,
    output logic [AMT_W-1:0]          chunk_size,
    output logic                      last,
    output logic                      error
);

    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    logic [BLK_W-1:0]  blk_reg;
    logic [AMT_W-1:0]  mop_reg;
    logic [BLK_W-1:0]  grain;
    logic [AMT_W-1:0]  limit;

    logic [OFF_W-1:0]  req_start_reg;
    logic [AMT_W-1:0]  req_amount_reg;
    logic [BLK_W-1:0]  m0_reg, m_reg;
    logic [COFF_W-1:0] cur_reg;
    logic [AMT_W-1:0]  rem_reg, left_reg, min_reg, ideal_reg;
    logic [CNT_W-1:0]  count_reg;
    logic signed [REL_W-1:0] e_reg, l_reg, n_reg;

    logic [DVD_W-1:0]  dvd;
    logic [AMT_W-1:0]  dsr;
    logic              wide;
    logic [31:0]       t;
    logic              div_done;
    logic [DVD_W-1:0]  quot;
    logic [AMT_W-1:0]  rmd;
    logic              r_nz;
    logic [REL_W-1:0]  t_down, t_up;
    logic signed [REL_W-1:0] sel;

    logic              rv_reg;
    logic [COFF_W-1:0] off_reg;
    logic [AMT_W-1:0]  size_reg;
    logic              last_reg, err_reg;

    assign grain = (blk_reg == '0) ? BLK_W'(1) : blk_reg;
    assign limit = (mop_reg == '0) ? AMT_W'(1) : mop_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg <= BLK_RESET;
            mop_reg <= MOP_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BLOCK_SIZE)
                blk_reg <= cfg_data[BLK_W-1:0];
            else if (cfg_index == REG_MAX_OP_SIZE)
                mop_reg <= cfg_data;
        end
    end

    // divider operand selection
    always_comb
    begin
        wide = 1'b0;
        t    = 32'(m_reg) + 32'(min_reg);
        dvd  = DVD_W'(t);
        dsr  = AMT_W'(grain);
        unique case (cmd.div_sel)
            DIV_MOD0:
            begin
                wide = 1'b1;
                dvd  = DVD_W'(req_start_reg);
            end
            DIV_LEFT:
            begin
                dvd = DVD_W'(rem_reg);
                dsr = limit;
            end
            DIV_IDEAL:
            begin
                dvd = DVD_W'(rem_reg);
                dsr = left_reg;
            end
            DIV_EMOD: t = 32'(m_reg) + 32'(min_reg);
            DIV_LMOD: t = 32'(m_reg) + 32'(limit);
            DIV_NMOD: t = 32'(m_reg) + 32'(ideal_reg);
        endcase
        if (cmd.div_sel == DIV_EMOD || cmd.div_sel == DIV_LMOD || cmd.div_sel == DIV_NMOD)
            dvd = DVD_W'(t);
    end

    aeios_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .wide     (wide),
        .dividend (dvd),
        .divisor  (dsr),
        .done     (div_done),
        .quot     (quot),
        .rmd      (rmd)
    );

    // alignment of the trial point and clamping
    assign r_nz   = (rmd != '0);
    assign t_down = REL_W'(t) - REL_W'(rmd);
    assign t_up   = r_nz ? (t_down + REL_W'(grain)) : REL_W'(t);

    always_comb
    begin
        sel = n_reg;
        if (sel < e_reg)
            sel = e_reg;
        if (sel > l_reg)
            sel = l_reg;
    end

    // request state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load || cmd.restart)
            count_reg <= '0;
        else if (cmd.advance)
            count_reg <= count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_start_reg  <= start_offset;
            req_amount_reg <= byte_amount;
            cur_reg        <= COFF_W'(start_offset);
            rem_reg        <= byte_amount;
        end
        if (cmd.restart)
        begin
            cur_reg <= COFF_W'(req_start_reg);
            rem_reg <= req_amount_reg;
            m_reg   <= m0_reg;
        end
        if (cmd.advance)
        begin
            cur_reg <= cur_reg + COFF_W'(sel[AMT_W-1:0]);
            rem_reg <= rem_reg - sel[AMT_W-1:0];
            m_reg   <= '0;
        end
        if (cmd.cap)
        begin
            unique case (cmd.div_sel)
                DIV_MOD0:
                begin
                    m0_reg <= rmd[BLK_W-1:0];
                    m_reg  <= rmd[BLK_W-1:0];
                end
                DIV_LEFT:
                begin
                    left_reg <= quot[AMT_W-1:0] + AMT_W'(r_nz);
                    min_reg  <= r_nz ? rmd : limit;
                end
                DIV_IDEAL: ideal_reg <= quot[AMT_W-1:0] + AMT_W'(r_nz);
                DIV_EMOD:  e_reg <= $signed(t_up) - $signed(REL_W'(m_reg));
                DIV_LMOD:  l_reg <= $signed(t_down) - $signed(REL_W'(m_reg));
                DIV_NMOD:  n_reg <= $signed(t_down) - $signed(REL_W'(m_reg));
            endcase
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= cmd.emit_final || cmd.emit_chunk || cmd.emit_err;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_final)
        begin
            off_reg  <= cur_reg;
            size_reg <= rem_reg;
            last_reg <= 1'b1;
            err_reg  <= 1'b0;
        end
        else if (cmd.emit_chunk)
        begin
            off_reg  <= cur_reg;
            size_reg <= sel[AMT_W-1:0];
            last_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            off_reg  <= COFF_W'(req_start_reg);
            size_reg <= '0;
            last_reg <= 1'b1;
            err_reg  <= 1'b1;
        end
    end

    // status to the sequencer
    always_comb
    begin
        status.amount_zero = (byte_amount == '0);
        status.div_done    = div_done;
        status.left_one    = (quot[AMT_W-1:0] == '0) ||
                             ((quot[AMT_W-1:0] == AMT_W'(1)) && !r_nz);
        status.count_full  = (count_reg == CNT_W'(MAX_CHUNKS));
        status.no_adv      = (sel <= 0);
    end

    assign result_valid = rv_reg;
    assign chunk_offset = off_reg;
    assign chunk_size   = size_reg;
    assign last         = last_reg;
    assign error        = err_reg;

endmodule
`default_nettype wire

[sv/aligned_even_io_splitter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aligned_even_io_splitter_top
// Cuts one I/O request into block-aligned, evenly sized chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: pulse start with start_offset and byte_amount while busy
//   is low. A zero amount is taken and gives no result.
//   Results: each chunk shows for one cycle with result_valid high; last
//   marks the final one. A request that needs more than MAX_CHUNKS chunks, or
//   cannot advance, gives a single result with error and last set.
//   Config channel: cfg_valid with cfg_index/cfg_data, cfg_ready always high;
//   write only while busy is low.
// Operation:
//   The request is planned twice through one shared bit-serial divider: a
//   checking pass, then an emitting pass. Start offset modulo block size is
//   a 64-step division done once. A chunk before the last needs five 32-step
//   divisions plus a step state, the last chunk one division. The final
//   result shows in the first cycle with busy low. An error found in the
//   checking pass ends the request early.
// Reset clears the sequencer and restores the config defaults. The receiver
// cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module aligned_even_io_splitter_top
    import aeios_pkg::*;
#(
    parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OFF_W-1:0]     start_offset,
    input  wire logic [AMT_W-1:0]     byte_amount,
    output logic                      result_valid,
    output logic [COFF_W-1:0]         chunk_offset,
    output logic [AMT_W-1:0]          chunk_size,
    output logic                      last,
    output logic                      error,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMT_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    busy_int;

    assign cfg_ready = 1'b1;
    assign busy      = busy_int;

    // sequencer
    aeios_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy_int),
        .cmd    (cmd)
    );

    // datapath
    aeios_dp #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_offset (start_offset),
        .byte_amount  (byte_amount),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .chunk_offset (chunk_offset),
        .chunk_size   (chunk_size),
        .last         (last),
        .error        (error)
    );

endmodule
`default_nettype wire

[sv/aeios_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeios_checker
// Port-level checks of the splitter, bound to the top level.
// ----------------------------------------------------------------------------
module aeios_checker
    import aeios_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [AMT_W-1:0]  byte_amount,
    input wire logic              result_valid,
    input wire logic [AMT_W-1:0]  chunk_size,
    input wire logic              last,
    input wire logic              error
);

    // error result is a final, empty one
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> last && chunk_size == '0)
        else $error("error result not final or not empty");

    // normal chunks are never empty
    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !error |-> chunk_size != '0)
        else $error("empty chunk");

    // a nonzero request keeps the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && byte_amount != '0 |=> busy)
        else $error("busy not raised");

    // more chunks follow a non-final one
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("idle in the middle of a request");

endmodule

bind aligned_even_io_splitter_top aeios_checker u_aeios_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .byte_amount  (byte_amount),
    .result_valid (result_valid),
    .chunk_size   (chunk_size),
    .last         (last),
    .error        (error)
);
`default_nettype wire
